### rtl/core/bfs_pkg.sv
// Package for the button frequency setter: field widths, limits, the
// step table and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package bfs_pkg;

    // field widths
    localparam int unsigned FREQ_W = 20;
    localparam int unsigned STEP_W = 3;
    localparam int unsigned CMP_W  = 16;
    localparam int unsigned HALF_W = 15;
    localparam int unsigned CLK_W  = 25;

    // dividend width of the shared divider (clock register and one million)
    localparam int unsigned DVD_W  = 25;
    localparam int unsigned CNT_W  = $clog2(DVD_W + 1);

    // frequency limits and reset values
    localparam logic [FREQ_W-1:0] FREQ_MIN    = FREQ_W'(17);
    localparam logic [FREQ_W-1:0] FREQ_MAX    = FREQ_W'(1000000);
    localparam logic [FREQ_W-1:0] FREQ_RESET  = FREQ_W'(95);
    localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(16000000);
    localparam logic [STEP_W-1:0] STEP_TOP    = STEP_W'(6);

    // one million, dividend of the period division
    localparam logic [DVD_W-1:0]  US_PER_S    = DVD_W'(1000000);

    // largest quotient whose compare value still fits
    localparam logic [DVD_W-1:0]  QUO_SAT     = DVD_W'(65536);

    // controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIVC = 5'b00100,
        S_DIVH = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic upd;        // take the button sample and update the settings
        logic load_cmp;   // load divider with clock / (2 * prescale * freq)
        logic load_half;  // load divider with one million / freq
        logic div_step;   // one restoring division step
        logic save_cmp;   // keep the saturated compare value
        logic out_load;   // move the result into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;   // no division steps left
        logic out_free;   // output register can take a new item
    } t_sts;

    // step size for a given exponent
    function automatic logic [FREQ_W-1:0] step_value(input logic [STEP_W-1:0] exp_i);
        logic [FREQ_W-1:0] v;
        unique case (exp_i)
            3'd0:    v = FREQ_W'(1);
            3'd1:    v = FREQ_W'(10);
            3'd2:    v = FREQ_W'(100);
            3'd3:    v = FREQ_W'(1000);
            3'd4:    v = FREQ_W'(10000);
            3'd5:    v = FREQ_W'(100000);
            3'd6:    v = FREQ_W'(1000000);
            default: v = FREQ_W'(1);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bfs_in_if.sv
// Input channel of the button frequency setter: one button sample per item.
// Depends on nothing.
`default_nettype none

interface bfs_in_if;
    logic valid;
    logic ready;
    logic inc_button_down;
    logic dec_button_down;
    logic step_button_down;

    modport source (output valid, output inc_button_down, output dec_button_down,
                    output step_button_down, input ready);
    modport sink   (input valid, input inc_button_down, input dec_button_down,
                    input step_button_down, output ready);
endinterface

`default_nettype wire

### rtl/core/bfs_out_if.sv
// Result channel of the button frequency setter.
// Depends on bfs_pkg for the field widths.
`default_nettype none

interface bfs_out_if
    import bfs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency_hz;
    logic [STEP_W-1:0] step_exponent;
    logic [CMP_W-1:0]  compare_value;
    logic [HALF_W-1:0] half_period_us;

    modport source (output valid, output frequency_hz, output step_exponent,
                    output compare_value, output half_period_us, input ready);
    modport sink   (input valid, input frequency_hz, input step_exponent,
                    input compare_value, input half_period_us, output ready);
endinterface

`default_nettype wire

### rtl/core/bfs_cfg_if.sv
// Configuration write channel: the timer clock register.
// Depends on bfs_pkg for the field width.
`default_nettype none

interface bfs_cfg_if
    import bfs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] cpu_clock_hz;

    modport source (output valid, output cpu_clock_hz, input ready);
    modport sink   (input valid, input cpu_clock_hz, output ready);
endinterface

`default_nettype wire

### rtl/core/bfs_ctrl.sv
// Controller of the button frequency setter: sequences update, the two
// divisions and the hand-over to the output register.
// Depends on bfs_pkg.
`default_nettype none

module bfs_ctrl
    import bfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.load_cmp = 1'b1;
                n_state        = S_DIVC;
            end
            S_DIVC: begin
                if (i_sts.div_done) begin
                    o_cmd.save_cmp  = 1'b1;
                    o_cmd.load_half = 1'b1;
                    n_state         = S_DIVH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVH: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted item always starts the compare division next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PREP))
        else $error("accepted item did not move to preparation");

    // the period division is followed by the hand-over
    a_half_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVH) && i_sts.div_done |=> (r_state == S_DONE))
        else $error("period division end not followed by hand-over");

    // a result only moves into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded into a full output register");

endmodule

`default_nettype wire

### rtl/core/bfs_dpath.sv
// Datapath of the button frequency setter: settings registers, press
// detection, shared restoring divider and the output register.
// Depends on bfs_pkg.
`default_nettype none

module bfs_dpath
    import bfs_pkg::*;
#(
    parameter int unsigned PRESCALE = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_inc,
    input  wire logic              i_dec,
    input  wire logic              i_stp,
    input  wire logic              i_cfg_we,
    input  wire logic [CLK_W-1:0]  i_cfg_clk,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [FREQ_W-1:0]      o_freq,
    output logic [STEP_W-1:0]      o_step,
    output logic [CMP_W-1:0]       o_cmp,
    output logic [HALF_W-1:0]      o_half
);

    localparam int unsigned MUL_W = $clog2(2 * PRESCALE + 1);
    localparam int unsigned DEN_W = FREQ_W + MUL_W;
    localparam logic [DEN_W-1:0] DEN_MUL = DEN_W'(2 * PRESCALE);

    // settings and press history
    logic [CLK_W-1:0]  r_clk_hz;
    logic [FREQ_W-1:0] r_freq, n_freq;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_inc_was, r_dec_was, r_stp_was;

    // divider
    logic [DEN_W-1:0]  r_div;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DVD_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;

    // results
    logic [CMP_W-1:0]  r_cmp, n_cmp;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic [STEP_W-1:0] r_out_step;
    logic [CMP_W-1:0]  r_out_cmp;
    logic [HALF_W-1:0] r_out_half;

    // frequency and step update on new presses
    always_comb begin
        logic [FREQ_W-1:0] step;
        logic [FREQ_W:0]   f;
        logic [FREQ_W:0]   low;
        step = step_value(r_step);
        f    = {1'b0, r_freq};
        low  = {1'b0, step} + {1'b0, FREQ_MIN};
        if (i_inc && !r_inc_was) begin
            f = f + {1'b0, step};
            if (f > {1'b0, FREQ_MAX}) begin
                f = {1'b0, FREQ_MAX};
            end
            if (f < {1'b0, FREQ_MIN}) begin
                f = {1'b0, FREQ_MIN};
            end
        end
        if (i_dec && !r_dec_was) begin
            if (f < low) begin
                f = {1'b0, FREQ_MIN};
            end else begin
                f = f - {1'b0, step};
            end
        end
        n_freq = f[FREQ_W-1:0];
        n_step = r_step;
        if (i_stp && !r_stp_was) begin
            n_step = (r_step >= STEP_TOP) ? '0 : r_step + STEP_W'(1);
        end
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (!w_diff[DEN_W]) begin
            n_rem = w_diff[DEN_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[DEN_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    // compare value: quotient minus one, saturated both ways
    always_comb begin
        if (r_quo == '0) begin
            n_cmp = '0;
        end else if (r_quo > QUO_SAT) begin
            n_cmp = '1;
        end else begin
            n_cmp = CMP_W'(r_quo - DVD_W'(1));
        end
    end

    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz    <= CLOCK_RESET;
            r_freq      <= FREQ_RESET;
            r_step      <= '0;
            r_inc_was   <= 1'b0;
            r_dec_was   <= 1'b0;
            r_stp_was   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_clk;
            end
            if (i_cmd.upd) begin
                r_freq    <= n_freq;
                r_step    <= n_step;
                r_inc_was <= i_inc;
                r_dec_was <= i_dec;
                r_stp_was <= i_stp;
            end
            if (i_cmd.load_cmp || i_cmd.load_half) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmp) begin
            r_div <= DEN_W'(r_freq) * DEN_MUL;
            r_rem <= '0;
            r_quo <= DVD_W'(r_clk_hz);
        end else if (i_cmd.load_half) begin
            r_div <= DEN_W'(r_freq);
            r_rem <= '0;
            r_quo <= US_PER_S;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.save_cmp) begin
            r_cmp <= n_cmp;
        end
        if (i_cmd.out_load) begin
            r_out_freq <= r_freq;
            r_out_step <= r_step;
            r_out_cmp  <= r_cmp;
            r_out_half <= r_quo[HALF_W:1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_freq      = r_out_freq;
    assign o_step      = r_out_step;
    assign o_cmp       = r_out_cmp;
    assign o_half      = r_out_half;

endmodule

`default_nettype wire

### rtl/core/button_frequency_setter.sv
// Button frequency setter, top level.
// Depends on bfs_pkg, bfs_in_if, bfs_out_if, bfs_cfg_if, bfs_ctrl, bfs_dpath.
//
// Usage:
//   i_item carries one sample of the increase, decrease and step buttons.
//   Only a new press (a 1 after a 0) acts: increase, then decrease, add or
//   subtract the current step, clamped to 17..1000000 Hz; the step button
//   cycles the step through 1..1000000.
//   o_result gives one item per sample: frequency, step exponent, timer
//   compare value clock / (2 * PRESCALE * freq) - 1 saturated to 16 bits,
//   and half the period in microseconds.
//   i_cfg writes the timer clock register; it is always ready and is to be
//   written only while the block is idle.
// Sequencing:
//   one item at a time; a sample is accepted, its compare division and then
//   its period division run on a shared one-bit-per-cycle restoring divider
//   (25 steps each), the result moves into the output register, and only
//   then is the next sample accepted.
// Reset: frequency 95 Hz, step exponent 0, no button held, clock 16 MHz.
// Stall: the result waits in the output register; a further sample is still
//   accepted and worked on, and its result waits until the register is taken.
`default_nettype none

module button_frequency_setter
    import bfs_pkg::*;
#(
    parameter int unsigned PRESCALE = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfs_in_if.sink     i_item,
    bfs_cfg_if.sink    i_cfg,
    bfs_out_if.source  o_result
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;

    // sequencing
    bfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // settings, divider and output register
    bfs_dpath #(
        .PRESCALE (PRESCALE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_inc       (i_item.inc_button_down),
        .i_dec       (i_item.dec_button_down),
        .i_stp       (i_item.step_button_down),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_clk   (i_cfg.cpu_clock_hz),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_freq      (o_result.frequency_hz),
        .o_step      (o_result.step_exponent),
        .o_cmp       (o_result.compare_value),
        .o_half      (o_result.half_period_us)
    );

endmodule

`default_nettype wire
